### hdl/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants of the keyframe track interpolator.
// ----------------------------------------------------------------------------
package kti_pkg;

  localparam int unsigned Frames   = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned ChanW    = 24;
  localparam int unsigned Channels = 5;
  localparam int unsigned EntryW   = ChanW * Channels;
  localparam int unsigned DistW    = IdxW + 1;
  localparam int unsigned ProdW    = ChanW + 1 + DistW + 1;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqRead  = 1'b1;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [EntryW-1:0] entry_t;

  // request from the sequencer to the divider
  typedef struct packed {
    logic                    start;
    logic signed [ProdW-1:0] num;
    logic [DistW-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ProdW-1:0] quot;
  } div_rsp_t;

endpackage

### hdl/kti_div.sv
// ----------------------------------------------------------------------------
// kti_div
// Serial signed divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module kti_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kti_pkg::div_req_t  req_i,
  output kti_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned W  = kti_pkg::ProdW;
  localparam int unsigned DW = kti_pkg::DistW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[DW-1:0], quo_q[W-1]};
    trial   = shifted - {1'b0, den_q};
    if (req_i.start) begin
      neg_d  = req_i.num[W-1];
      quo_d  = req_i.num[W-1] ? W'(-req_i.num) : W'(req_i.num);
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DW]) begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

### hdl/kti_store.sv
// ----------------------------------------------------------------------------
// kti_store
// Keyframe channel memory, one port read with registered data, one write.
// ----------------------------------------------------------------------------
module kti_store (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [kti_pkg::IdxW-1:0]     waddr_i,
  input  kti_pkg::entry_t              wdata_i,
  input  logic [kti_pkg::IdxW-1:0]     raddr_i,
  output kti_pkg::entry_t              rdata_o
);

  kti_pkg::entry_t mem [kti_pkg::Frames];
  kti_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/keyframe_track_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_track_interpolator
// Keyframe track store with linear in-between frame interpolation.
// ----------------------------------------------------------------------------
// A write beat stores a keyframe, and the input stays ready for the next
// beat. A read beat of a keyframe passes through StReadA, StWaitA and StOut
// to its result beat. A read of any other frame first scans the key marks
// one frame a cycle, down to the keyframe below and up to the next keyframe
// or the end of the track. A frame after the last keyframe then takes the
// same path as a keyframe. An in-between frame adds a second memory read
// (StReadB, StWaitB) and five serial divides, one per channel, after the
// scan. A stalled result beat holds the block until it is taken. Frame 0
// reads as zero until written; it needs no clearing pass because its mark
// and a written flag for it are held in flip-flops.
module keyframe_track_interpolator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // frame_index, pos_x_in, pos_y_in, scale_x_in, scale_y_in, rotation_in
  // (126 bits, padded to 128)
  input  logic [127:0]  s_axis_tdata_i,
  // req_type
  input  logic          s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // pos_x, pos_y, scale_x, scale_y, rotation
  output logic [119:0]  m_axis_tdata_o,
  // frame_is_key
  output logic          m_axis_tuser_o
);

  localparam int unsigned IW = kti_pkg::IdxW;
  localparam int unsigned CW = kti_pkg::ChanW;
  localparam int unsigned DW = kti_pkg::DistW;
  localparam int unsigned PW = kti_pkg::ProdW;

  typedef enum logic [3:0] {
    StIdle, StScanLo, StScanHi, StReadA, StWaitA, StReadB, StWaitB,
    StMul, StDiv, StNext, StOut
  } state_e;

  state_e state_q;
  logic [kti_pkg::Frames-1:0] marks_q;
  logic        f0_written_q;
  logic [IW-1:0] j_q, k0_q, k1_q, scan_q;
  logic        found_q, key_q;
  logic [2:0]  ch_q;
  kti_pkg::entry_t a_q, b_q, res_q;
  logic signed [PW-1:0] prod_q;
  logic        out_valid_q;
  kti_pkg::entry_t out_data_q;
  logic        out_key_q;

  logic        req;
  logic [IW-1:0] idx;
  kti_pkg::entry_t wdata, rdata, rfix;
  logic        we;
  logic [IW-1:0] raddr;
  kti_pkg::div_req_t dreq;
  kti_pkg::div_rsp_t drsp;
  logic signed [CW:0] diff;
  logic signed [CW-1:0] ach, bch, qch;

  assign req   = s_axis_tuser_i;
  assign idx   = s_axis_tdata_i[IW-1:0];
  assign wdata = s_axis_tdata_i[IW+kti_pkg::EntryW-1:IW];
  assign s_axis_tready_o = (state_q == StIdle);
  assign we = s_axis_tvalid_i && s_axis_tready_o && (req == kti_pkg::ReqWrite);
  assign raddr = (state_q == StReadB) ? k1_q : k0_q;

  kti_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // frame 0 reads as zero until its first write
  always_comb begin
    rfix = rdata;
    if (k0_q == '0 && state_q == StWaitA && !f0_written_q) begin
      rfix = '0;
    end
  end

  assign ach  = a_q[ch_q*CW +: CW];
  assign bch  = b_q[ch_q*CW +: CW];
  assign diff = (CW+1)'(bch) - (CW+1)'(ach);
  assign dreq.start = (state_q == StMul);
  assign dreq.num   = prod_q;
  assign dreq.den   = DW'(k1_q) - DW'(k0_q);
  assign qch = ach + CW'(drsp.quot);

  kti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      marks_q      <= {{(kti_pkg::Frames-1){1'b0}}, 1'b1};
      f0_written_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid_i) begin
            j_q    <= idx;
            scan_q <= idx;
            if (req == kti_pkg::ReqWrite) begin
              marks_q[idx] <= 1'b1;
              if (idx == '0) f0_written_q <= 1'b1;
            end else if (marks_q[idx]) begin
              key_q   <= 1'b1;
              found_q <= 1'b0;
              k0_q    <= idx;
              state_q <= StReadA;
            end else begin
              key_q   <= 1'b0;
              found_q <= 1'b0;
              state_q <= StScanLo;
            end
          end
        end
        StScanLo: begin
          if (marks_q[scan_q - 1'b1]) begin
            k0_q    <= scan_q - 1'b1;
            scan_q  <= j_q;
            state_q <= StScanHi;
          end else begin
            scan_q <= scan_q - 1'b1;
          end
        end
        StScanHi: begin
          if (scan_q == IW'(kti_pkg::Frames - 1)) begin
            state_q <= StReadA;
          end else if (marks_q[scan_q + 1'b1]) begin
            k1_q    <= scan_q + 1'b1;
            found_q <= 1'b1;
            state_q <= StReadA;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        StReadA: state_q <= StWaitA;
        StWaitA: begin
          a_q   <= rfix;
          res_q <= rfix;
          ch_q  <= '0;
          state_q <= found_q ? StReadB : StOut;
        end
        StReadB: state_q <= StWaitB;
        StWaitB: begin
          b_q     <= rdata;
          state_q <= StNext;
        end
        StNext: begin
          prod_q  <= PW'(diff) * $signed({1'b0, DW'(j_q) - DW'(k0_q)});
          state_q <= StMul;
        end
        StMul: state_q <= StDiv;
        StDiv: begin
          if (drsp.done) begin
            res_q[ch_q*CW +: CW] <= qch;
            if (ch_q == 3'(kti_pkg::Channels - 1)) begin
              state_q <= StOut;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= StNext;
            end
          end
        end
        StOut: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            out_key_q   <= key_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (out_valid_q && m_axis_tready_i && state_q != StOut) out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_key_q;

endmodule
